### hw/rtl/rla_pkg.sv
// rla_pkg: shared constants for the RF level alarm.
// Register indexes, field widths and divider step counts.
// No dependencies.
package rla_pkg;

    localparam int WINDOW_LEN_DEF = 20;

    localparam int SAMPLE_W   = 12;
    localparam int STRENGTH_W = 4;
    localparam int THR_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int STEP_W     = 4;

    localparam int AVG_QW = 12;   // quotient bits of sum / WINDOW_LEN
    localparam int STR_QW = 5;    // quotient bits of diff*10 / sensitivity

    localparam logic [STRENGTH_W-1:0] STRENGTH_FULL = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd4;

    localparam logic [SAMPLE_W-1:0] BASELINE_RST    = 12'd0;
    localparam logic [SAMPLE_W-1:0] SENSITIVITY_RST = 12'd1500;
    localparam logic [THR_W-1:0]    ON_THR_RST      = 4'd6;
    localparam logic [THR_W-1:0]    OFF_THR_RST     = 4'd4;

endpackage

### hw/rtl/rf_level_alarm.sv
// rf_level_alarm: moving-average level detector with hysteresis alarm.
// One shared adder/subtractor under a sequencer; window kept in a small RAM.
// Depends on rla_pkg.
//
//  channel  dir  handshake         payload
//  s_       in   s_tvalid/tready   s_tdata[11:0] sample, [12] restart
//  m_       out  m_tvalid/tready   m_tdata average, strength, alarm, alert, lowest, highest
//  cfg_     in   cfg_we            cfg_index, cfg_data
//
// Each item runs through the sequencer steps in order: the window sum reads the RAM one
// entry per cycle, a constant reciprocal multiply forms the average, then 5 restoring
// divide steps on the same adder give the strength. A disabled item goes straight to
// the output step. s_tready is high only while the sequencer is idle. A result waits in
// the output register; the sequencer holds its last step until that register is free.
// Reset is synchronous on aresetn and clears control state only.
module rf_level_alarm #(
    parameter int WINDOW_LEN = rla_pkg::WINDOW_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [12] restart, [15:13] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [11:0] average, [15:12] strength, [16] alarm,
                                   // [17] alert, [29:18] lowest, [41:30] highest

    input  logic                           cfg_we,
    input  logic [rla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rla_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CW = $clog2(WINDOW_LEN + 1);
    localparam int W  = (13 + IW > 16) ? 13 + IW : 16;
    localparam int SW = rla_pkg::SAMPLE_W;

    // floor(sum / WINDOW_LEN) as (sum * RCP_M) >> RCP_SH, exact for every window sum
    localparam int RCP_SH = SW + 2 * IW;
    localparam int RCP_W  = RCP_SH - IW + 2;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((longint'(1) << RCP_SH) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIVA = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIVS = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // configuration
    logic [SW-1:0]                  baseline_reg;
    logic [SW-1:0]                  sensitivity_reg;
    logic [rla_pkg::THR_W-1:0]      on_thr_reg;
    logic [rla_pkg::THR_W-1:0]      off_thr_reg;
    logic                           enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg    <= rla_pkg::BASELINE_RST;
            sensitivity_reg <= rla_pkg::SENSITIVITY_RST;
            on_thr_reg      <= rla_pkg::ON_THR_RST;
            off_thr_reg     <= rla_pkg::OFF_THR_RST;
            enable_reg      <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                rla_pkg::REG_BASELINE:    baseline_reg    <= cfg_data[SW-1:0];
                rla_pkg::REG_SENSITIVITY: sensitivity_reg <= cfg_data[SW-1:0];
                rla_pkg::REG_ON_THR:      on_thr_reg      <= cfg_data[rla_pkg::THR_W-1:0];
                rla_pkg::REG_OFF_THR:     off_thr_reg     <= cfg_data[rla_pkg::THR_W-1:0];
                rla_pkg::REG_ENABLE:      enable_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state
    logic [2:0]                     state_reg, state_next;
    logic [WINDOW_LEN-1:0]          mask_reg, mask_next;
    logic [IW-1:0]                  wpos_reg, wpos_next;
    logic                           alarm_reg, alarm_next;
    logic                           ext_set_reg, ext_set_next;
    logic [SW-1:0]                  min_reg, min_next;
    logic [SW-1:0]                  max_reg, max_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [IW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [W-1:0]                   acc_reg, acc_next;
    logic [W-1:0]                   sub_reg, sub_next;
    logic [rla_pkg::AVG_QW-1:0]     q_reg, q_next;
    logic [rla_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [SW-1:0]                  avg_reg, avg_next;
    logic                           pos_reg, pos_next;
    logic                           zero_reg, zero_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [47:0]                    m_tdata_reg, m_tdata_next;

    // window RAM
    logic [SW-1:0] mem [WINDOW_LEN];
    logic [SW-1:0] mem_q;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          rd_en;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_tdata[SW-1:0];
        end
        if (rd_en) begin
            mem_q <= mem[cnt_reg[IW-1:0]];
        end
    end

    // shared adder
    logic [W-1:0] alu_a, alu_b;
    logic         alu_cin;
    logic [W:0]   alu_sum;

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{W{1'b0}}, alu_cin};

    logic [W+RCP_W-1:0] avg_prod;

    assign avg_prod = {{RCP_W{1'b0}}, acc_reg} * {{W{1'b0}}, RCP_M};

    logic                          accept;
    logic                          restart;
    logic [WINDOW_LEN-1:0]         base_mask;
    logic [IW-1:0]                 base_pos;
    logic [SW-1:0]                 entry;
    logic                          take;
    logic                          out_free;
    logic [SW-1:0]                 mn, mx;
    logic [rla_pkg::STR_QW-1:0]    sq;
    logic [rla_pkg::STRENGTH_W-1:0] strength;
    logic                          alert;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tdata[12];
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_en    = (state_reg == ST_SUM) && (cnt_reg < CW'(WINDOW_LEN));
    assign entry    = mask_reg[rd_idx_reg] ? mem_q : baseline_reg;
    assign take     = alu_sum[W];
    assign sq       = q_reg[rla_pkg::STR_QW-1:0];
    assign strength = !pos_reg ? '0 :
                      (sq > rla_pkg::STR_QW'(rla_pkg::STRENGTH_FULL)) ?
                      rla_pkg::STRENGTH_FULL : sq[rla_pkg::STRENGTH_W-1:0];
    assign alert    = (strength >= on_thr_reg);
    assign mn       = ext_set_reg ? min_reg : baseline_reg;
    assign mx       = ext_set_reg ? max_reg : baseline_reg;

    always_comb begin
        base_mask = restart ? '0 : mask_reg;
        base_pos  = restart ? '0 : wpos_reg;
    end

    always_comb begin
        alu_a   = acc_reg;
        alu_b   = ~sub_reg;
        alu_cin = 1'b1;
        case (state_reg)
            ST_SUM: begin
                alu_b   = W'(entry);
                alu_cin = 1'b0;
            end
            ST_DIFF: begin
                alu_a = W'(q_reg[SW-1:0]);
                alu_b = ~W'(baseline_reg);
            end
            ST_MUL: begin
                alu_a   = W'({acc_reg[SW-1:0], 3'b000});
                alu_b   = W'({acc_reg[SW-1:0], 1'b0});
                alu_cin = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        wpos_next     = wpos_reg;
        alarm_next    = alarm_reg;
        ext_set_next  = ext_set_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        acc_next      = acc_reg;
        sub_next      = sub_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        avg_next      = avg_reg;
        pos_next      = pos_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = base_pos;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (restart) begin
                        alarm_next   = 1'b0;
                        ext_set_next = 1'b0;
                    end
                    mask_next = base_mask;
                    wpos_next = base_pos;
                    if (!enable_reg) begin
                        alarm_next = 1'b0;
                        zero_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        mem_we              = 1'b1;
                        mask_next[base_pos] = 1'b1;
                        wpos_next = (base_pos == IW'(WINDOW_LEN - 1)) ? '0 : base_pos + 1'b1;
                        zero_next  = 1'b0;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                rd_idx_next = cnt_reg[IW-1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    acc_next = alu_sum[W-1:0];
                end
                if (cnt_reg == CW'(WINDOW_LEN)) begin
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA: begin
                q_next     = avg_prod[RCP_SH +: rla_pkg::AVG_QW];
                state_next = ST_DIFF;
            end
            ST_DIVS: begin
                if (take) begin
                    acc_next = alu_sum[W-1:0];
                end
                q_next    = {q_reg[rla_pkg::AVG_QW-2:0], take};
                sub_next  = sub_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_DIFF: begin
                avg_next     = q_reg[SW-1:0];
                pos_next     = take && (alu_sum[W-1:0] != '0);
                acc_next     = alu_sum[W-1:0];
                ext_set_next = 1'b1;
                min_next     = (q_reg[SW-1:0] < mn) ? q_reg[SW-1:0] : mn;
                max_next     = (q_reg[SW-1:0] > mx) ? q_reg[SW-1:0] : mx;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = alu_sum[W-1:0];
                sub_next   = W'(sensitivity_reg) << (rla_pkg::STR_QW - 1);
                step_next  = rla_pkg::STEP_W'(rla_pkg::STR_QW - 1);
                q_next     = '0;
                state_next = ST_DIVS;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (zero_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        if (!alarm_reg && alert) begin
                            alarm_next = 1'b1;
                        end else if (alarm_reg && (strength <= off_thr_reg)) begin
                            alarm_next = 1'b0;
                        end
                        m_tdata_next = {6'b0, max_reg, min_reg, alert,
                                        (!alarm_reg && alert) ? 1'b1 :
                                        (alarm_reg && (strength <= off_thr_reg)) ? 1'b0 :
                                        alarm_reg,
                                        strength, avg_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            wpos_reg     <= '0;
            alarm_reg    <= 1'b0;
            ext_set_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            wpos_reg     <= wpos_next;
            alarm_reg    <= alarm_next;
            ext_set_reg  <= ext_set_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg     <= min_next;
        max_reg     <= max_next;
        cnt_reg     <= cnt_next;
        rd_idx_reg  <= rd_idx_next;
        acc_reg     <= acc_next;
        sub_reg     <= sub_next;
        q_reg       <= q_next;
        step_reg    <= step_next;
        avg_reg     <= avg_next;
        pos_reg     <= pos_next;
        zero_reg    <= zero_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### dv/testbench.sv
// testbench: self-checking bench for rf_level_alarm.
// Stream driver and monitor with an in-bench average/strength/alarm predictor.
// Depends on rla_pkg and rf_level_alarm.
module testbench;

    localparam int WLEN          = rla_pkg::WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int SEG_ITEMS     = 40;

    typedef struct packed {
        logic                         restart;
        logic [rla_pkg::SAMPLE_W-1:0] sample;
    } sample_item_t;

    typedef struct packed {
        logic [rla_pkg::SAMPLE_W-1:0]   average;
        logic [rla_pkg::STRENGTH_W-1:0] strength;
        logic                           alarm;
        logic                           alert;
        logic [rla_pkg::SAMPLE_W-1:0]   lowest;
        logic [rla_pkg::SAMPLE_W-1:0]   highest;
    } level_reading_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [47:0]                    m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [rla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rla_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    rf_level_alarm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and detector state
    logic [rla_pkg::SAMPLE_W-1:0] cur_baseline;
    logic [rla_pkg::SAMPLE_W-1:0] cur_sensitivity;
    logic [rla_pkg::THR_W-1:0]    cur_on_thr;
    logic [rla_pkg::THR_W-1:0]    cur_off_thr;
    logic                         cur_enable;
    logic [rla_pkg::SAMPLE_W-1:0] win_mem [WLEN];
    logic [WLEN-1:0]              win_filled;
    int                           win_pos;
    logic                         alarm_state;
    logic                         extremes_armed;
    logic [rla_pkg::SAMPLE_W-1:0] avg_min;
    logic [rla_pkg::SAMPLE_W-1:0] avg_max;

    sample_item_t   pending_samples[$];
    level_reading_t due_readings[$];
    sample_item_t   next_item;
    level_reading_t mon_want;
    level_reading_t mon_got;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int cycles        = 0;
    int items_taken   = 0;
    int restarts_sent = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int alarm_rises   = 0;
    int cfg_writes    = 0;

    function automatic level_reading_t track_level(sample_item_t it);
        level_reading_t r;
        int slot;
        int total;
        int q;
        int i;
        r = '0;
        if (it.restart) begin
            win_filled     = '0;
            win_pos        = 0;
            alarm_state    = 1'b0;
            extremes_armed = 1'b1;
        end
        if (!cur_enable) begin
            alarm_state = 1'b0;
            return r;
        end
        slot = (win_pos >= WLEN) ? 0 : win_pos;
        win_mem[slot]    = it.sample;
        win_filled[slot] = 1'b1;
        win_pos = (slot + 1 >= WLEN) ? 0 : slot + 1;
        total = 0;
        for (i = 0; i < WLEN; i++)
            total += win_filled[i] ? int'(win_mem[i]) : int'(cur_baseline);
        r.average = rla_pkg::SAMPLE_W'(total / WLEN);
        if (extremes_armed) begin
            avg_min        = cur_baseline;
            avg_max        = cur_baseline;
            extremes_armed = 1'b0;
        end
        if (r.average < avg_min) avg_min = r.average;
        if (r.average > avg_max) avg_max = r.average;
        q = 0;
        if (r.average > cur_baseline) begin
            if (cur_sensitivity == 0)
                q = int'(rla_pkg::STRENGTH_FULL);
            else
                q = (int'(r.average) - int'(cur_baseline)) * int'(rla_pkg::STRENGTH_FULL)
                    / int'(cur_sensitivity);
            if (q > int'(rla_pkg::STRENGTH_FULL)) q = int'(rla_pkg::STRENGTH_FULL);
        end
        r.strength = rla_pkg::STRENGTH_W'(q);
        if (!alarm_state && r.strength >= cur_on_thr) begin
            alarm_state = 1'b1;
            alarm_rises++;
        end else if (alarm_state && r.strength <= cur_off_thr) begin
            alarm_state = 1'b0;
        end
        r.alarm   = alarm_state;
        r.alert   = (r.strength >= cur_on_thr);
        r.lowest  = avg_min;
        r.highest = avg_max;
        return r;
    endfunction

    task automatic note_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d, %s: expected %0d, got %0d",
                     results_seen, field, want, got);
    endtask

    task automatic write_reg(logic [rla_pkg::CFG_IDX_W-1:0] idx,
                             logic [rla_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rla_pkg::REG_BASELINE:    cur_baseline    = data;
            rla_pkg::REG_SENSITIVITY: cur_sensitivity = data;
            rla_pkg::REG_ON_THR:      cur_on_thr      = data[rla_pkg::THR_W-1:0];
            rla_pkg::REG_OFF_THR:     cur_off_thr     = data[rla_pkg::THR_W-1:0];
            rla_pkg::REG_ENABLE:      cur_enable      = data[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic push_sample(int s, bit rs);
        sample_item_t it;
        it.sample  = rla_pkg::SAMPLE_W'(s);
        it.restart = rs;
        pending_samples.push_back(it);
    endtask

    // sender holds off until every queued item has its result back
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || due_readings.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic pick_settings();
        int bl;
        int sens;
        int on_t;
        int off_t;
        int hi;
        bl   = $urandom_range(9);
        bl   = (bl == 0) ? 0 : (bl == 1) ? 4095 : $urandom_range(0, 2500);
        sens = $urandom_range(11);
        sens = (sens == 0) ? 0 : (sens == 1) ? 4095 : (sens == 2) ? 1
             : $urandom_range(200, 3500);
        on_t = ($urandom_range(9) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
        if ($urandom_range(9) == 0)
            off_t = $urandom_range(0, 15);
        else
            off_t = (on_t == 0) ? 0 : $urandom_range(0, (on_t > 10 ? 10 : on_t - 1));
        hi = $urandom_range(1) ? $urandom_range(0, 2047) : 0;
        write_reg(rla_pkg::REG_BASELINE, rla_pkg::CFG_DATA_W'(bl));
        write_reg(rla_pkg::REG_SENSITIVITY, rla_pkg::CFG_DATA_W'(sens));
        write_reg(rla_pkg::REG_ON_THR, {hi[7:0], on_t[3:0]});
        write_reg(rla_pkg::REG_OFF_THR, {hi[10:3], off_t[3:0]});
        write_reg(rla_pkg::REG_ENABLE, {hi[10:0], 1'b1 ^ ($urandom_range(9) == 0)});
    endtask

    // levels held for a while so the average settles across the thresholds
    task automatic queue_levels(int n);
        int k;
        int level;
        int spread;
        int hold;
        int s;
        hold   = 0;
        level  = int'(cur_baseline);
        spread = 0;
        @(negedge aclk);
        for (k = 0; k < n; k++) begin
            if (hold == 0) begin
                hold = $urandom_range(4, 24);
                case ($urandom_range(3))
                    0: level = int'(cur_baseline);
                    1: level = int'(cur_baseline) - int'($urandom_range(0, 300));
                    default: level = int'(cur_baseline)
                        + int'($urandom_range(0, 12)) * int'(cur_sensitivity) / 10;
                endcase
                spread = $urandom_range(0, 64);
            end
            hold--;
            if ($urandom_range(9) == 0)
                s = $urandom_range(0, 4095);
            else
                s = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
            push_sample(s, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_readings.push_back(track_level({s_tdata[12], s_tdata[11:0]}));
                items_taken++;
                if (s_tdata[12]) restarts_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_item = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, next_item.restart, next_item.sample};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_readings.size() == 0) begin
                    note_mismatch("unexpected item", 0, 1);
                end else begin
                    mon_want = due_readings.pop_front();
                    mon_got.average  = m_tdata[11:0];
                    mon_got.strength = m_tdata[15:12];
                    mon_got.alarm    = m_tdata[16];
                    mon_got.alert    = m_tdata[17];
                    mon_got.lowest   = m_tdata[29:18];
                    mon_got.highest  = m_tdata[41:30];
                    if (mon_got.average !== mon_want.average)
                        note_mismatch("average", int'(mon_want.average),
                                      int'(mon_got.average));
                    if (mon_got.strength !== mon_want.strength)
                        note_mismatch("strength", int'(mon_want.strength),
                                      int'(mon_got.strength));
                    if (mon_got.alarm !== mon_want.alarm)
                        note_mismatch("alarm", int'(mon_want.alarm), int'(mon_got.alarm));
                    if (mon_got.alert !== mon_want.alert)
                        note_mismatch("alert", int'(mon_want.alert), int'(mon_got.alert));
                    if (mon_got.lowest !== mon_want.lowest)
                        note_mismatch("lowest", int'(mon_want.lowest),
                                      int'(mon_got.lowest));
                    if (mon_got.highest !== mon_want.highest)
                        note_mismatch("highest", int'(mon_want.highest),
                                      int'(mon_got.highest));
                end
                results_seen++;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        int ph;
        int seg;
        int k;
        cur_baseline    = rla_pkg::BASELINE_RST;
        cur_sensitivity = rla_pkg::SENSITIVITY_RST;
        cur_on_thr      = rla_pkg::ON_THR_RST;
        cur_off_thr     = rla_pkg::OFF_THR_RST;
        cur_enable      = 1'b1;
        win_filled      = '0;
        win_pos         = 0;
        alarm_state     = 1'b0;
        extremes_armed  = 1'b1;
        avg_min         = '0;
        avg_max         = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // full-scale climb from reset values, then restart
        @(negedge aclk);
        for (k = 0; k < 6; k++) push_sample(4095, 1'b0);
        push_sample(0, 1'b1);
        wait_drained();
        // disabled, including a restart while disabled
        write_reg(rla_pkg::REG_ENABLE, 12'd0);
        push_sample(4095, 1'b0);
        push_sample(123, 1'b1);
        wait_drained();
        // top baseline, average below baseline
        write_reg(rla_pkg::REG_ENABLE, 12'hffe | 12'h001);
        write_reg(rla_pkg::REG_BASELINE, 12'd4095);
        write_reg(rla_pkg::REG_SENSITIVITY, 12'd4095);
        push_sample(4095, 1'b0);
        push_sample(0, 1'b1);
        wait_drained();
        // baseline moved without restart: unwritten entries follow it
        write_reg(rla_pkg::REG_BASELINE, 12'd100);
        push_sample(4095, 1'b0);
        wait_drained();
        // zero sensitivity, thresholds above ten
        write_reg(rla_pkg::REG_BASELINE, 12'd0);
        write_reg(rla_pkg::REG_SENSITIVITY, 12'd0);
        write_reg(rla_pkg::REG_ON_THR, 12'h0fb);
        write_reg(rla_pkg::REG_OFF_THR, 12'h00f);
        push_sample(2000, 1'b1);
        push_sample(0, 1'b0);
        wait_drained();
        // inverted thresholds: alarm toggles
        write_reg(rla_pkg::REG_ON_THR, 12'd0);
        write_reg(rla_pkg::REG_OFF_THR, 12'd10);
        push_sample(0, 1'b1);
        push_sample(4095, 1'b0);
        push_sample(4095, 1'b0);
        push_sample(12'h555, 1'b0);
        push_sample(12'haaa, 1'b0);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            for (seg = 0; seg < 3; seg++) begin
                pick_settings();
                queue_levels(SEG_ITEMS);
                wait_drained();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d samples, %0d with restart, %0d register writes, four idle mixes",
                 items_taken, restarts_sent, cfg_writes);
        $display("%0d results checked, %0d alarm turn-ons, %0d mismatches",
                 results_seen, alarm_rises, mismatches);
        if (mismatches == 0 && due_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/rla_pkg.sv
hw/rtl/rf_level_alarm.sv
dv/testbench.sv
